>>> rtl/core/eso_pkg.sv
// ----------------------------------------------------------------------------
// Encoder odometer package
// Shared widths, command codes, register indexes and reset defaults of the odometer block.
// ----------------------------------------------------------------------------
package eso_pkg;

   localparam int CountWidth = 32;
   localparam int RevWidth   = 24;
   localparam int DtWidth    = 16;
   localparam int PosWidth   = 64;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_RESET  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      REG_PERIOD   = 3'd0,
      REG_CPR      = 3'd1,
      REG_CIRC     = 3'd2,
      REG_LEFT_INV = 3'd3,
      REG_RIGHT_INV = 3'd4
   } reg_index_type;

   localparam logic [CountWidth-1:0] PeriodReset = 32'd65535;
   localparam logic [RevWidth-1:0]   CprReset    = 24'd56000;
   localparam logic [RevWidth-1:0]   CircReset   = 24'd208916;
   localparam logic [15:0]           MaxSpeed2   = 16'd6000;

endpackage

>>> rtl/core/encoder_sample_odometer.sv
// ----------------------------------------------------------------------------
// Encoder sample odometer
// Per-wheel wrap-aware encoder delta, speed, trust check and position.
// ----------------------------------------------------------------------------
// A word on the req_ channel names a wheel and either samples its counter or
// resets the wheel. Each request gives one rsp_ word. Configuration words on
// the csr_ channel are taken at any time; write them only while idle.
// A sample that computes a speed makes two passes of the shared restoring divider,
// each for a 64-bit quotient: one for the speed and one for the trust bound.
// A zero interval or zero geometry skips a divider pass.
// A reset command or a first sample uses no divider pass.
// Only one request is in flight; req_stall is high from acceptance until the
// response word is taken. The response register holds while rsp_stall is
// high. Reset clears all wheel state and loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_sample_odometer #(
   parameter int NUM_WHEELS = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic                                 req_wheel_select,
   input  logic [eso_pkg::CountWidth-1:0]       req_counter_value,
   input  logic [eso_pkg::DtWidth-1:0]          req_interval_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [31:0]                   rsp_delta_counts,
   output logic signed [31:0]                   rsp_raw_delta,
   output logic signed [63:0]                   rsp_position_counts,
   output logic signed [31:0]                   rsp_speed_mmps,
   output logic                                 rsp_trusted,
   output logic [31:0]                          rsp_sample_sequence,
   output logic [31:0]                          rsp_trusted_total,
   output logic [31:0]                          rsp_untrusted_total,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [2:0]                           csr_index,
   input  logic [31:0]                          csr_data
);
   import eso_pkg::*;

   localparam int WheelBits = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DELTA, ST_MUL_A, ST_MUL_B, ST_DIV_SPD, ST_MUL_T1, ST_MUL_T2,
      ST_DIV_TR, ST_UPDATE, ST_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] period_ff;
   logic [23:0] cpr_ff, circ_ff;
   logic [NUM_WHEELS-1:0] inv_ff;

   logic [31:0] last_ff [NUM_WHEELS];
   logic [63:0] pos_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] primed_ff;
   logic [31:0] seq_ff [NUM_WHEELS];
   logic [31:0] tru_ff [NUM_WHEELS];
   logic [31:0] unt_ff [NUM_WHEELS];

   logic        cmd_ff, valid_whl_ff;
   logic [WheelBits-1:0] whl_ff;
   logic [31:0] now_ff;
   logic [15:0] dt_ff;
   logic signed [31:0] raw_ff, delta_ff, speed_ff;
   logic [63:0] prod_ff;
   logic [47:0] den_ff;
   logic        neg_ff, ok_ff;
   logic        div_start_ff;
   logic        div_done;
   logic [63:0] div_q;

   logic        r_valid_ff;
   logic signed [31:0] r_delta_ff, r_raw_ff, r_speed_ff;
   logic [63:0] r_pos_ff;
   logic        r_ok_ff;
   logic [31:0] r_seq_ff, r_tru_ff, r_unt_ff;

   // Wrap logic on 34-bit signed values.
   logic signed [33:0] modulo, half, diff, dwrap;
   logic [31:0] mag;
   logic [WheelBits-1:0] whl_sel;

   assign whl_sel = req_wheel_select ? WheelBits'(1) : WheelBits'(0);
   assign modulo = $signed({2'b00, period_ff}) + 34'sd1;
   assign half   = modulo >>> 1;
   assign diff   = $signed({2'b00, now_ff}) - $signed({2'b00, last_ff[whl_ff]});
   always_comb begin
      if (diff > half) dwrap = diff - modulo;
      else if (diff < -half) dwrap = diff + modulo;
      else dwrap = diff;
   end
   assign mag = delta_ff[31] ? 32'(-delta_ff) : 32'(delta_ff);

   eso_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend(prod_ff), .divisor(den_ff), .done(div_done), .quotient(div_q)
   );

   assign req_stall = (state_ff != ST_IDLE) || r_valid_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PeriodReset;
         cpr_ff       <= CprReset;
         circ_ff      <= CircReset;
         inv_ff       <= (NUM_WHEELS > 1) ? NUM_WHEELS'(2) : '0;
         primed_ff    <= '0;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            last_ff[i] <= '0;
            pos_ff[i]  <= '0;
            seq_ff[i]  <= '0;
            tru_ff[i]  <= '0;
            unt_ff[i]  <= '0;
         end
         r_valid_ff   <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (r_valid_ff && !rsp_stall) r_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_PERIOD:    period_ff <= csr_data;
               REG_CPR:       cpr_ff    <= csr_data[23:0];
               REG_CIRC:      circ_ff   <= csr_data[23:0];
               REG_LEFT_INV:  inv_ff[0] <= csr_data[0];
               REG_RIGHT_INV: if (NUM_WHEELS > 1) inv_ff[WheelBits'(1)] <= csr_data[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  cmd_ff       <= req_command;
                  whl_ff       <= whl_sel;
                  valid_whl_ff <= (32'(req_wheel_select) < 32'(NUM_WHEELS));
                  now_ff       <= req_counter_value;
                  dt_ff        <= req_interval_ms;
                  raw_ff       <= '0;
                  delta_ff     <= '0;
                  speed_ff     <= '0;
                  ok_ff        <= 1'b0;
                  state_ff     <= ST_DELTA;
               end
            end
            ST_DELTA: begin
               if (!valid_whl_ff || cmd_ff == CMD_RESET || !primed_ff[whl_ff]) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  raw_ff <= dwrap[31:0];
                  if (inv_ff[whl_ff]) begin
                     delta_ff <= (dwrap[31:0] == 32'h8000_0000) ? 32'sh7FFF_FFFF
                                                               : -$signed(dwrap[31:0]);
                  end else begin
                     delta_ff <= dwrap[31:0];
                  end
                  state_ff <= ST_MUL_A;
               end
            end
            ST_MUL_A: begin
               neg_ff  <= delta_ff[31];
               prod_ff <= 64'(mag) * 64'(circ_ff);
               den_ff  <= 48'(cpr_ff) * 48'(dt_ff);
               if (dt_ff == '0 || cpr_ff == '0 || circ_ff == '0) begin
                  state_ff <= ST_MUL_T1;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_SPD;
               end
            end
            ST_DIV_SPD: begin
               if (div_done) begin
                  if (neg_ff) begin
                     speed_ff <= (div_q > 64'd2147483648) ? 32'sh8000_0000
                                                          : 32'(-div_q);
                  end else begin
                     speed_ff <= (div_q > 64'd2147483647) ? 32'sh7FFF_FFFF
                                                          : 32'(div_q);
                  end
                  state_ff <= ST_MUL_T1;
               end
            end
            ST_MUL_T1: begin
               prod_ff  <= 64'(dt_ff) * 64'(MaxSpeed2);
               state_ff <= ST_MUL_T2;
            end
            ST_MUL_T2: begin
               // The interval times 6000 needs 29 bits.
               prod_ff <= 64'(53'(prod_ff[28:0]) * 53'(cpr_ff));
               den_ff  <= 48'(circ_ff);
               if (dt_ff == '0) begin
                  ok_ff    <= 1'b0;
                  state_ff <= ST_UPDATE;
               end else if (circ_ff == '0) begin
                  ok_ff    <= 1'b1;
                  state_ff <= ST_UPDATE;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_TR;
               end
            end
            ST_DIV_TR: begin
               if (div_done) begin
                  ok_ff    <= (64'(mag) <= div_q);
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (valid_whl_ff) begin
                  last_ff[whl_ff]   <= now_ff;
                  primed_ff[whl_ff] <= 1'b1;
                  if (cmd_ff == CMD_RESET) begin
                     pos_ff[whl_ff] <= '0;
                     seq_ff[whl_ff] <= '0;
                     tru_ff[whl_ff] <= '0;
                     unt_ff[whl_ff] <= '0;
                  end else begin
                     seq_ff[whl_ff] <= seq_ff[whl_ff] + 32'd1;
                     if (ok_ff) begin
                        pos_ff[whl_ff] <= pos_ff[whl_ff] + 64'($signed(delta_ff));
                        tru_ff[whl_ff] <= tru_ff[whl_ff] + 32'd1;
                     end else begin
                        unt_ff[whl_ff] <= unt_ff[whl_ff] + 32'd1;
                     end
                  end
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               r_valid_ff <= 1'b1;
               r_delta_ff <= delta_ff;
               r_raw_ff   <= raw_ff;
               r_speed_ff <= speed_ff;
               r_ok_ff    <= ok_ff;
               r_pos_ff   <= valid_whl_ff ? pos_ff[whl_ff] : '0;
               r_seq_ff   <= valid_whl_ff ? seq_ff[whl_ff] : '0;
               r_tru_ff   <= valid_whl_ff ? tru_ff[whl_ff] : '0;
               r_unt_ff   <= valid_whl_ff ? unt_ff[whl_ff] : '0;
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = r_valid_ff;
   assign rsp_delta_counts    = r_delta_ff;
   assign rsp_raw_delta       = r_raw_ff;
   assign rsp_position_counts = r_pos_ff;
   assign rsp_speed_mmps      = r_speed_ff;
   assign rsp_trusted         = r_ok_ff;
   assign rsp_sample_sequence = r_seq_ff;
   assign rsp_trusted_total   = r_tru_ff;
   assign rsp_untrusted_total = r_unt_ff;
endmodule

>>> rtl/core/eso_divider.sv
// ----------------------------------------------------------------------------
// Encoder odometer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eso_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [48:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] trial;

   assign trial = {rem_ff[47:0], quo_ff[63]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder sample odometer testbench
// Drives sample and reset words for both wheels under several register
// settings, predicts every response word from a local model of the wheel
// state and compares each field in order of arrival.
// ----------------------------------------------------------------------------
module tb;
   import eso_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic        req_wheel_select;
   logic [31:0] req_counter_value;
   logic [15:0] req_interval_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_delta_counts;
   logic signed [31:0] rsp_raw_delta;
   logic signed [63:0] rsp_position_counts;
   logic signed [31:0] rsp_speed_mmps;
   logic        rsp_trusted;
   logic [31:0] rsp_sample_sequence;
   logic [31:0] rsp_trusted_total;
   logic [31:0] rsp_untrusted_total;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   typedef struct packed {
      logic signed [31:0] delta;
      logic signed [31:0] raw;
      logic signed [63:0] position;
      logic signed [31:0] speed;
      logic               trusted;
      logic [31:0]        sequence_n;
      logic [31:0]        trusted_n;
      logic [31:0]        untrusted_n;
   } odo_word_t;

   encoder_sample_odometer dut (.*);

   // Local copy of the registers and wheel state.
   logic [31:0] period_q;
   logic [23:0] cpr_q;
   logic [23:0] circ_q;
   logic        inv_q [2];
   logic [31:0] last_q [2];
   logic [63:0] pos_q [2];
   logic        primed_q [2];
   logic [31:0] seq_q [2];
   logic [31:0] trc_q [2];
   logic [31:0] untrc_q [2];

   odo_word_t expected_words[$];
   int  mismatches = 0;
   int  idle_pct = 37;
   int  hold_cycles = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic odo_word_t predict_word(logic cmd, logic w, logic [31:0] now,
                                              logic [15:0] dt);
      odo_word_t r;
      longint modv, half, d, num, den, q, mag, bound;
      logic signed [31:0] dl;
      r = '0;
      if (cmd == CMD_RESET) begin
         last_q[w] = now; primed_q[w] = 1;
         pos_q[w] = 0; seq_q[w] = 0; trc_q[w] = 0; untrc_q[w] = 0;
      end else if (!primed_q[w]) begin
         last_q[w] = now; primed_q[w] = 1;
         seq_q[w]++; untrc_q[w]++;
      end else begin
         modv = longint'(period_q) + 1;
         half = modv / 2;
         d = longint'(now) - longint'(last_q[w]);
         if (d > half) d -= modv;
         else if (d < -half) d += modv;
         r.raw = d[31:0];
         last_q[w] = now;
         dl = r.raw;
         if (inv_q[w]) dl = (r.raw == 32'sh80000000) ? 32'sh7fffffff : -r.raw;
         r.delta = dl;
         if (dt != 0 && cpr_q != 0 && circ_q != 0) begin
            num = longint'(dl) * longint'(circ_q);
            den = longint'(cpr_q) * longint'(dt);
            q = num / den;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            r.speed = q[31:0];
         end
         if (dt == 0) r.trusted = 0;
         else if (circ_q == 0) r.trusted = 1;
         else begin
            mag = longint'(dl);
            if (mag < 0) mag = -mag;
            bound = 3000 * longint'(dt) * longint'(cpr_q) * 2;
            bound = bound / longint'(circ_q);
            r.trusted = (mag <= bound);
         end
         if (r.trusted) begin
            pos_q[w] += {{32{dl[31]}}, dl};
            trc_q[w]++;
         end else untrc_q[w]++;
         seq_q[w]++;
      end
      r.position = pos_q[w];
      r.sequence_n = seq_q[w];
      r.trusted_n = trc_q[w];
      r.untrusted_n = untrc_q[w];
      return r;
   endfunction

   // Valid stays high after acceptance; it drops only while idling or draining.
   task automatic send_word(logic cmd, logic w, logic [31:0] now, logic [15:0] dt);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_command <= cmd; req_wheel_select <= w;
      req_counter_value <= now; req_interval_ms <= dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(predict_word(cmd, w, now, dt));
   endtask

   task automatic drain_words();
      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_PERIOD:    period_q = val;
         REG_CPR:       cpr_q = val[23:0];
         REG_CIRC:      circ_q = val[23:0];
         REG_LEFT_INV:  inv_q[0] = val[0];
         REG_RIGHT_INV: inv_q[1] = val[0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [31:0] p, logic [31:0] c, logic [31:0] ci,
                           logic li, logic ri);
      drain_words();
      write_reg(REG_PERIOD, p);
      write_reg(REG_CPR, c);
      write_reg(REG_CIRC, ci);
      write_reg(REG_LEFT_INV, {31'd0, li});
      write_reg(REG_RIGHT_INV, {31'd0, ri});
      csr_valid <= 0;
   endtask

   // Random walk of a wheel counter: mostly small plausible moves.
   function automatic logic [31:0] next_count(logic w, logic [31:0] limit);
      logic [31:0] v;
      case ($urandom_range(9))
         0: v = $urandom();
         1: v = limit;
         default: v = last_q[w] + $urandom_range(400) - 200;
      endcase
      if ($urandom_range(9) != 0 && limit != 32'hffffffff) v = v % (limit + 1);
      return v;
   endfunction

   task automatic test_directed();
      send_word(CMD_SAMPLE, 0, 32'd100, 16'd10);  // first sample on left
      send_word(CMD_SAMPLE, 1, 32'hffffffff, 16'hffff);  // beyond period
      send_word(CMD_SAMPLE, 0, 32'd65535, 16'd10);  // wraps backward
      send_word(CMD_SAMPLE, 0, 32'd5, 16'd0);       // zero interval
      send_word(CMD_SAMPLE, 1, 32'd0, 16'd1);
      send_word(CMD_SAMPLE, 1, 32'd300, 16'd1);
      send_word(CMD_RESET, 0, 32'h0, 16'hffff);
      send_word(CMD_SAMPLE, 0, 32'd40, 16'd5);
      send_word(CMD_RESET, 1, 32'hffffffff, 16'd0);
      send_word(CMD_SAMPLE, 1, 32'hfffffff0, 16'd3);
   endtask

   task automatic test_extremes();
      // Full period: most negative raw delta, polarity saturation.
      set_regs(32'hffffffff, 32'd1, 32'hffffff, 1, 1);
      send_word(CMD_RESET, 0, 32'h0, 16'd1);
      send_word(CMD_SAMPLE, 0, 32'h80000000, 16'd1);
      send_word(CMD_SAMPLE, 0, 32'h0, 16'd1);
      send_word(CMD_SAMPLE, 0, 32'h7fffffff, 16'hffff);
      send_word(CMD_RESET, 1, 32'h80000001, 16'd1);
      send_word(CMD_SAMPLE, 1, 32'h00000001, 16'd1);
      // A period of one and zero-sized geometry.
      set_regs(32'd1, 32'd0, 32'd0, 0, 0);
      send_word(CMD_SAMPLE, 0, 32'd3, 16'd2);
      send_word(CMD_SAMPLE, 0, 32'd0, 16'd2);
      set_regs(32'd1, 32'd0, 32'd1, 0, 0);
      send_word(CMD_SAMPLE, 0, 32'd1, 16'd2);
      send_word(CMD_SAMPLE, 0, 32'd1, 16'd2);
      set_regs(32'd1000, 32'hffffff, 32'd1, 1, 0);
      send_word(CMD_SAMPLE, 1, 32'd999, 16'hffff);
   endtask

   task automatic test_random(int n, logic [31:0] limit);
      logic cmd, w;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(1);
         cmd = ($urandom_range(29) == 0) ? CMD_RESET : CMD_SAMPLE;
         send_word(cmd, w, next_count(w, limit),
                   ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(40)));
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      for (int i = 0; i < 6; i++) send_word(CMD_SAMPLE, i[0], $urandom_range(2000), 16'd5);
      drain_words();   // sender pauses until every response is in
   endtask

   // Response stall generator, with a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      odo_word_t a, e;
      if (!reset && rsp_valid && !rsp_stall) begin
         a = '{rsp_delta_counts, rsp_raw_delta, rsp_position_counts, rsp_speed_mmps,
               rsp_trusted, rsp_sample_sequence, rsp_trusted_total, rsp_untrusted_total};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response word %h", a);
         end else begin
            e = expected_words.pop_front();
            if (a !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %h actual %h", e, a);
            end
         end
      end
   end

   initial begin
      #40000000;
      $display("FAIL encoder_sample_odometer");
      $finish;
   end

   initial begin
      reset = 1; req_valid = 0; req_command = 0; req_wheel_select = 0;
      req_counter_value = 0; req_interval_ms = 0; csr_valid = 0; csr_index = 0;
      csr_data = 0;
      period_q = PeriodReset; cpr_q = CprReset; circ_q = CircReset;
      inv_q[0] = 0; inv_q[1] = 1;
      for (int i = 0; i < 2; i++) begin
         last_q[i] = 0; pos_q[i] = 0; primed_q[i] = 0;
         seq_q[i] = 0; trc_q[i] = 0; untrc_q[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(300, PeriodReset);
      test_extremes();
      set_regs(32'd4095, 32'd2048, 32'd200000, 0, 1);
      idle_pct = 0;      // no idling on either side for a while
      test_random(250, 32'd4095);
      idle_pct = 37;
      test_backpressure();
      set_regs(32'hffffffff, 32'd56000, 32'd208916, 1, 0);
      test_random(300, 32'hffffffff);
      set_regs(32'd65535, 32'd100, 32'd5000, 0, 1);
      test_random(380, 32'd65535);
      drain_words();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("PASS encoder_sample_odometer");
      else
         $display("FAIL encoder_sample_odometer");
      $finish;
   end
endmodule

>>> files.f
rtl/core/eso_pkg.sv
rtl/core/eso_divider.sv
rtl/core/encoder_sample_odometer.sv
bench/tb.sv
